// File: hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

	localparam int UNIT_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 16;
	localparam int CP_W    = 21;

	localparam logic [UNIT_W-1:0] SURR_MASK = 16'hFC00;
	localparam logic [UNIT_W-1:0] HIGH_BASE = 16'hD800;
	localparam logic [UNIT_W-1:0] LOW_BASE  = 16'hDC00;
	localparam logic [UNIT_W-1:0] BITS_MASK = 16'h03FF;
	localparam logic [CP_W-1:0]   PAIR_OFFSET = 21'h010000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// configuration register index, taken from paddr[2]
	localparam logic REG_OUT_CAPACITY = 1'b0;
	localparam logic REG_COUNT_ONLY   = 1'b1;
	localparam int   APB_ADDR_W       = 3;
	localparam int   APB_DATA_W       = 32;

	// one character (or terminator) worth of output bytes
	typedef struct packed {
		logic [3:0][BYTE_W-1:0] bytes;
		logic [1:0]             last;
		logic                   stored;
		logic                   eos;
		logic [COUNT_W-1:0]     total;
		logic                   fit;
		logic                   stop;
	} char_rec_t;

endpackage

// File: hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates, keeps run state and encodes each
// character into a record of up to four bytes for the back end.
// ----------------------------------------------------------------------------
module u16u8_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          q_full,
	input  logic [15:0]                   code_unit,
	input  logic [15:0]                   out_capacity,
	input  logic                          count_only,
	output logic                          rec_we,
	output u16u8_pkg::char_rec_t          rec
);
	import u16u8_pkg::*;

	logic               high_pending_q;
	logic [9:0]         high_bits_q;
	logic               halted_q;
	logic [COUNT_W-1:0] byte_count_q;
	logic               still_fitting_q;

	logic               high_pending_d;
	logic [9:0]         high_bits_d;
	logic               halted_d;
	logic [COUNT_W-1:0] byte_count_d;
	logic               still_fitting_d;

	logic               accept;
	logic               is_zero;
	logic               is_high;
	logic               is_low;
	logic               is_char;
	logic [CP_W-1:0]    cp;
	logic [3:0][7:0]    enc;
	logic [1:0]         enc_last;
	logic [COUNT_W:0]   count_sum;
	logic               stored;

	assign accept  = push && !q_full;
	assign is_zero = (code_unit == '0);
	assign is_high = ((code_unit & SURR_MASK) == HIGH_BASE);
	assign is_low  = ((code_unit & SURR_MASK) == LOW_BASE);

	// code point of a pair or of a single unit
	always_comb begin
		if (high_pending_q) begin
			cp = PAIR_OFFSET + {1'b0, high_bits_q, code_unit[9:0]};
		end else begin
			cp = {5'b0, code_unit};
		end
	end

	always_comb begin
		enc = '0;
		if (cp < 21'h80) begin
			enc[0]   = cp[7:0];
			enc_last = 2'd0;
		end else if (cp < 21'h800) begin
			enc[0]   = {3'b110, cp[10:6]};
			enc[1]   = {2'b10, cp[5:0]};
			enc_last = 2'd1;
		end else if (cp < 21'h10000) begin
			enc[0]   = {4'b1110, cp[15:12]};
			enc[1]   = {2'b10, cp[11:6]};
			enc[2]   = {2'b10, cp[5:0]};
			enc_last = 2'd2;
		end else begin
			enc[0]   = {5'b11110, cp[20:18]};
			enc[1]   = {2'b10, cp[17:12]};
			enc[2]   = {2'b10, cp[11:6]};
			enc[3]   = {2'b10, cp[5:0]};
			enc_last = 2'd3;
		end
	end

	assign count_sum = {1'b0, byte_count_q} + {15'b0, enc_last} + 17'd1;
	assign stored    = !count_only && still_fitting_q && ({1'b0, out_capacity} > count_sum);

	always_comb begin
		high_pending_d  = high_pending_q;
		high_bits_d     = high_bits_q;
		halted_d        = halted_q;
		byte_count_d    = byte_count_q;
		still_fitting_d = still_fitting_q;
		is_char         = 1'b0;
		rec_we          = 1'b0;
		rec             = '0;
		if (accept) begin
			if (is_zero) begin
				rec_we     = 1'b1;
				rec.eos    = 1'b1;
				rec.stop   = halted_q || high_pending_q;
				rec.fit    = still_fitting_q;
				if (!count_only) begin
					if (still_fitting_q && (out_capacity > byte_count_q)) begin
						rec.stored = 1'b1;
					end else begin
						rec.fit = 1'b0;
					end
				end
				rec.total = (byte_count_q == COUNT_MAX) ? COUNT_MAX
				                                       : byte_count_q + 16'd1;
				high_pending_d  = 1'b0;
				high_bits_d     = '0;
				halted_d        = 1'b0;
				byte_count_d    = '0;
				still_fitting_d = 1'b1;
			end else if (halted_q) begin
				// dropped until the terminator
			end else if (high_pending_q) begin
				high_pending_d = 1'b0;
				high_bits_d    = '0;
				if (!is_low) begin
					halted_d = 1'b1;
				end else begin
					is_char = 1'b1;
				end
			end else if (is_high) begin
				high_pending_d = 1'b1;
				high_bits_d    = code_unit[9:0];
			end else begin
				is_char = 1'b1;
			end
		end
		if (is_char) begin
			rec_we     = 1'b1;
			rec.bytes  = enc;
			rec.last   = enc_last;
			rec.stored = stored;
			if (!count_only && still_fitting_q && !stored) begin
				still_fitting_d = 1'b0;
			end
			byte_count_d = count_sum[COUNT_W] ? COUNT_MAX : count_sum[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q  <= 1'b0;
			high_bits_q     <= '0;
			halted_q        <= 1'b0;
			byte_count_q    <= '0;
			still_fitting_q <= 1'b1;
		end else begin
			high_pending_q  <= high_pending_d;
			high_bits_q     <= high_bits_d;
			halted_q        <= halted_d;
			byte_count_q    <= byte_count_d;
			still_fitting_q <= still_fitting_d;
		end
	end

endmodule

// File: hdl/u16u8_fifo.sv
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short queue of character records between the front and the back end.
// ----------------------------------------------------------------------------
module u16u8_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  u16u8_pkg::char_rec_t wr_data,
	input  logic                 rd_en,
	output u16u8_pkg::char_rec_t rd_data,
	output logic                 full,
	output logic                 empty
);
	import u16u8_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	char_rec_t          mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Walks the bytes of the oldest record, one per cycle while the output
// register is empty or popped, into it; it feeds the result queue interface.
// ----------------------------------------------------------------------------
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u16u8_pkg::char_rec_t head,
	input  logic                 q_empty,
	output logic                 q_rd,
	input  logic                 pop,
	output logic                 empty,
	output logic [7:0]           out_byte,
	output logic                 byte_stored,
	output logic                 end_of_string,
	output logic [15:0]          total_bytes,
	output logic                 all_fitted,
	output logic                 decode_stopped
);
	import u16u8_pkg::*;

	logic       out_v_q;
	logic [1:0] idx_q;
	logic       load;
	logic       take;

	logic [7:0]  out_byte_q;
	logic        byte_stored_q;
	logic        end_of_string_q;
	logic [15:0] total_bytes_q;
	logic        all_fitted_q;
	logic        decode_stopped_q;

	assign load = !out_v_q || pop;
	assign take = load && !q_empty;
	assign q_rd = take && (idx_q == head.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				out_v_q <= !q_empty;
			end
			if (q_rd) begin
				idx_q <= '0;
			end else if (take) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q       <= head.bytes[idx_q];
			byte_stored_q    <= head.stored;
			end_of_string_q  <= head.eos;
			total_bytes_q    <= head.total;
			all_fitted_q     <= head.fit;
			decode_stopped_q <= head.stop;
		end
	end

	assign empty          = !out_v_q;
	assign out_byte       = out_byte_q;
	assign byte_stored    = byte_stored_q;
	assign end_of_string  = end_of_string_q;
	assign total_bytes    = total_bytes_q;
	assign all_fitted     = all_fitted_q;
	assign decode_stopped = decode_stopped_q;

endmodule

// File: hdl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a zero-terminated stream of UTF-16 code units into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input side is a queue write port: an item (one code unit) is taken on an
// edge with push high and full low. Results come from a queue read port: the
// oldest byte sits on the result ports while empty is low and leaves on an
// edge with pop high. A zero unit ends the string and yields a zero byte with
// end_of_string, total_bytes, all_fitted and decode_stopped.
// The front end takes one unit per cycle while its record queue has room;
// the back end sends one byte per cycle while the receiver pops; a unit
// gives 1 to 3 bytes, or 2 per unit of a surrogate pair, all through that
// single output byte port. The first byte of a unit goes through the record
// queue into the output register before it is on the result ports.
// If the receiver stalls, the output register holds, the record queue fills
// and full rises; nothing is dropped. Reset clears the run state and the queue,
// empties the output register, and sets out_capacity and count_only to zero.
// out_capacity (address 0) and count_only (address 4) are written over APB;
// the user must write them only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic [15:0] code_unit,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        byte_stored,
	output logic        end_of_string,
	output logic [15:0] total_bytes,
	output logic        all_fitted,
	output logic        decode_stopped
);
	import u16u8_pkg::*;

	logic [15:0] out_capacity_q;
	logic        count_only_q;
	logic        cfg_we;

	logic        rec_we;
	char_rec_t   rec;
	char_rec_t   head;
	logic        q_full;
	logic        q_empty;
	logic        q_rd;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_capacity_q <= '0;
			count_only_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (paddr[2])
				REG_OUT_CAPACITY: out_capacity_q <= pwdata[15:0];
				REG_COUNT_ONLY:   count_only_q   <= pwdata[0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_OUT_CAPACITY: prdata = {16'b0, out_capacity_q};
			REG_COUNT_ONLY:   prdata = {31'b0, count_only_q};
			default:          prdata = '0;
		endcase
	end

	assign full = q_full;

	u16u8_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.q_full       (q_full),
		.code_unit    (code_unit),
		.out_capacity (out_capacity_q),
		.count_only   (count_only_q),
		.rec_we       (rec_we),
		.rec          (rec)
	);

	u16u8_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_we),
		.wr_data (rec),
		.rd_en   (q_rd),
		.rd_data (head),
		.full    (q_full),
		.empty   (q_empty)
	);

	u16u8_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.q_empty        (q_empty),
		.q_rd           (q_rd),
		.pop            (pop),
		.empty          (empty),
		.out_byte       (out_byte),
		.byte_stored    (byte_stored),
		.end_of_string  (end_of_string),
		.total_bytes    (total_bytes),
		.all_fitted     (all_fitted),
		.decode_stopped (decode_stopped)
	);

	// terminator item carries a zero byte
	a_eos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && end_of_string |-> out_byte == 8'h00)
		else $error("terminator item with nonzero byte");

	// summary fields only on the terminator
	a_summary_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !end_of_string |-> total_bytes == 16'h0000 && !all_fitted && !decode_stopped)
		else $error("summary field set on a data item");

	// count-only mode never stores
	a_count_only: assert property (@(posedge clk) disable iff (!arst_n)
		count_only_q && !empty |-> !byte_stored)
		else $error("byte stored in count-only mode");

	// a queue read only happens when the output register takes a byte
	a_rd_take: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |=> !empty)
		else $error("record retired without a result item");

endmodule
